// File: design/ptg_pkg.sv
package ptg_pkg;

   // Field widths
   localparam int VALUE_W    = 13;
   localparam int INDEX_W    = 9;
   localparam int LIMIT_W    = 10;
   localparam int DIV_W      = 4;
   localparam int STEP_W     = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Fixed values
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd500;
   localparam logic [VALUE_W-1:0] PRIME_TWO   = 13'd2;
   localparam logic [VALUE_W-1:0] PRIME_THREE = 13'd3;
   localparam logic [VALUE_W-1:0] CAND_STEP   = 13'd2;
   localparam logic [DIV_W-1:0]   DIV_STEPS   = 4'd13;

   // Register index carried in address bit 2
   localparam logic CSR_REG_LIMIT = 1'b0;

   typedef logic [STEP_W-1:0] step_type;

   // Program steps
   localparam step_type ST_ACCEPT    = 5'd0;
   localparam step_type ST_CHECK     = 5'd1;
   localparam step_type ST_IDX0      = 5'd2;
   localparam step_type ST_IDX1      = 5'd3;
   localparam step_type ST_LOAD_CAND = 5'd4;
   localparam step_type ST_ADVANCE   = 5'd5;
   localparam step_type ST_TEST      = 5'd6;
   localparam step_type ST_DIV_START = 5'd7;
   localparam step_type ST_DIV_STEP  = 5'd8;
   localparam step_type ST_REM_CHECK = 5'd9;
   localparam step_type ST_QUO_CHECK = 5'd10;
   localparam step_type ST_NEXT_DIV  = 5'd11;
   localparam step_type ST_SET_TWO   = 5'd12;
   localparam step_type ST_SET_THREE = 5'd13;
   localparam step_type ST_SET_CAND  = 5'd14;
   localparam step_type ST_STORE     = 5'd15;
   localparam step_type ST_OUT_PRIME = 5'd16;
   localparam step_type ST_PRIME_RET = 5'd17;
   localparam step_type ST_OUT_DONE  = 5'd18;
   localparam step_type ST_DONE_RET  = 5'd19;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_LOAD_CAND,
      OP_ADVANCE,
      OP_DIV_START,
      OP_DIV_STEP,
      OP_INC_K,
      OP_SET_TWO,
      OP_SET_THREE,
      OP_SET_CAND,
      OP_STORE,
      OP_OUT_PRIME,
      OP_OUT_DONE
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_DONE,
      C_IDX0,
      C_IDX1,
      C_K_END,
      C_D_ZERO,
      C_DIV_MORE,
      C_REM_ZERO,
      C_Q_LE_D,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   // Control store: one word per step, jump to target when cond holds
   function automatic ctrl_word_type ucode(input step_type step);
      ctrl_word_type w;
      unique case (step)
         ST_ACCEPT:    w = '{OP_ACCEPT,    C_NO_REQ,   ST_ACCEPT};
         ST_CHECK:     w = '{OP_NOP,       C_DONE,     ST_OUT_DONE};
         ST_IDX0:      w = '{OP_NOP,       C_IDX0,     ST_SET_TWO};
         ST_IDX1:      w = '{OP_NOP,       C_IDX1,     ST_SET_THREE};
         ST_LOAD_CAND: w = '{OP_LOAD_CAND, C_NEVER,    ST_ACCEPT};
         ST_ADVANCE:   w = '{OP_ADVANCE,   C_NEVER,    ST_ACCEPT};
         ST_TEST:      w = '{OP_NOP,       C_K_END,    ST_SET_CAND};
         ST_DIV_START: w = '{OP_DIV_START, C_D_ZERO,   ST_SET_CAND};
         ST_DIV_STEP:  w = '{OP_DIV_STEP,  C_DIV_MORE, ST_DIV_STEP};
         ST_REM_CHECK: w = '{OP_NOP,       C_REM_ZERO, ST_ADVANCE};
         ST_QUO_CHECK: w = '{OP_NOP,       C_Q_LE_D,   ST_SET_CAND};
         ST_NEXT_DIV:  w = '{OP_INC_K,     C_ALWAYS,   ST_TEST};
         ST_SET_TWO:   w = '{OP_SET_TWO,   C_ALWAYS,   ST_STORE};
         ST_SET_THREE: w = '{OP_SET_THREE, C_ALWAYS,   ST_STORE};
         ST_SET_CAND:  w = '{OP_SET_CAND,  C_NEVER,    ST_ACCEPT};
         ST_STORE:     w = '{OP_STORE,     C_NEVER,    ST_ACCEPT};
         ST_OUT_PRIME: w = '{OP_OUT_PRIME, C_OUT_BUSY, ST_OUT_PRIME};
         ST_PRIME_RET: w = '{OP_NOP,       C_ALWAYS,   ST_ACCEPT};
         ST_OUT_DONE:  w = '{OP_OUT_DONE,  C_OUT_BUSY, ST_OUT_DONE};
         ST_DONE_RET:  w = '{OP_NOP,       C_ALWAYS,   ST_ACCEPT};
         default:      w = '{OP_NOP,       C_ALWAYS,   ST_ACCEPT};
      endcase
      return w;
   endfunction

endpackage

// File: design/prime_table_generator.sv
// Prime table generator.
// Request channel (req_valid/req_stall, req_restart): each accepted beat asks
// for the next prime; req_restart high clears the sequence first, so the beat
// returns 2 at index 0. Response channel (rsp_valid/rsp_stall): exactly one
// beat per request, carrying the prime, its zero-based index, and done_res,
// which is set (prime and index zero) once prime_limit primes were produced.
// prime_limit sits at CSR byte address 0 and resets to 500; values above
// MAX_PRIMES act as MAX_PRIMES.
// One request is in work at a time. Later primes run odd candidates through
// a shared restoring divider (one quotient bit per cycle) against the stored
// odd primes, each divisor read from the table first.
// The request channel reopens after the return step that follows the loading
// of the response register, while that beat may still wait under rsp_stall;
// the sequencer holds at its output step only if the previous response is
// still stalled.
// Reset starts the sequence over, as a restart does; the table holds no
// clearing pass since only entries already written are read.
module prime_table_generator #(
   parameter int MAX_PRIMES = 512
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ptg_pkg::VALUE_W-1:0]           rsp_prime_value,
   output logic [ptg_pkg::INDEX_W-1:0]           rsp_prime_index,
   output logic                                  rsp_done_res,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ptg_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [ptg_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [ptg_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam int CNT_W = $clog2(MAX_PRIMES + 1);
   localparam int IDX_W = $clog2(MAX_PRIMES);
   localparam int CMP_W = (CNT_W > ptg_pkg::LIMIT_W) ? CNT_W : ptg_pkg::LIMIT_W;

   // Sequencer and datapath registers
   ptg_pkg::step_type                 pc_ff, pc_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  k_ff, k_in;
   logic [ptg_pkg::VALUE_W-1:0]       last_ff, last_in;
   logic [ptg_pkg::VALUE_W-1:0]       n_ff, n_in;
   logic [ptg_pkg::VALUE_W-1:0]       p_ff, p_in;
   logic [ptg_pkg::VALUE_W-1:0]       d_ff, d_in;
   logic [ptg_pkg::VALUE_W-1:0]       rem_ff, rem_in;
   logic [ptg_pkg::VALUE_W-1:0]       quo_ff, quo_in;
   logic [ptg_pkg::DIV_W-1:0]         div_cnt_ff, div_cnt_in;
   logic [ptg_pkg::LIMIT_W-1:0]       limit_ff, limit_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ptg_pkg::VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [ptg_pkg::INDEX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic                              rsp_done_ff, rsp_done_in;

   // Prime table
   logic [ptg_pkg::VALUE_W-1:0]       prime_mem [MAX_PRIMES];
   logic [ptg_pkg::VALUE_W-1:0]       rd_data_ff;

   ptg_pkg::ctrl_word_type            cw;
   logic                              cond_true;
   logic                              out_free;
   logic                              limit_reached;
   logic [CMP_W-1:0]                  lim_ext;
   logic [CMP_W-1:0]                  max_ext;
   logic [CMP_W-1:0]                  eff_limit;
   logic [ptg_pkg::VALUE_W:0]         div_shift;
   logic [ptg_pkg::VALUE_W:0]         div_diff;
   logic                              div_fits;
   logic                              csr_write;

   assign cw       = ptg_pkg::ucode(pc_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Saturate the limit to the table size
   assign lim_ext       = CMP_W'(limit_ff);
   assign max_ext       = CMP_W'(MAX_PRIMES);
   assign eff_limit     = (lim_ext > max_ext) ? max_ext : lim_ext;
   assign limit_reached = CMP_W'(count_ff) >= eff_limit;

   // One restoring divider step
   assign div_shift = {rem_ff, quo_ff[ptg_pkg::VALUE_W-1]};
   assign div_fits  = div_shift >= {1'b0, d_ff};
   assign div_diff  = div_shift - {1'b0, d_ff};

   // Evaluate jump condition
   always_comb begin
      unique case (cw.cond)
         ptg_pkg::C_NEVER:    cond_true = 1'b0;
         ptg_pkg::C_ALWAYS:   cond_true = 1'b1;
         ptg_pkg::C_NO_REQ:   cond_true = !req_valid;
         ptg_pkg::C_DONE:     cond_true = limit_reached;
         ptg_pkg::C_IDX0:     cond_true = count_ff == '0;
         ptg_pkg::C_IDX1:     cond_true = count_ff == CNT_W'(1);
         ptg_pkg::C_K_END:    cond_true = k_ff >= count_ff;
         ptg_pkg::C_D_ZERO:   cond_true = rd_data_ff == '0;
         ptg_pkg::C_DIV_MORE: cond_true = div_cnt_ff != ptg_pkg::DIV_W'(1);
         ptg_pkg::C_REM_ZERO: cond_true = rem_ff == '0;
         ptg_pkg::C_Q_LE_D:   cond_true = quo_ff <= d_ff;
         ptg_pkg::C_OUT_BUSY: cond_true = !out_free;
         default:             cond_true = 1'b0;
      endcase
   end

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == ptg_pkg::CSR_REG_LIMIT) ?
                       ptg_pkg::CSR_DATA_W'(limit_ff) : '0;

   // Datapath actions from the control word
   always_comb begin
      pc_in        = cond_true ? cw.target : pc_ff + ptg_pkg::STEP_W'(1);
      count_in     = count_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_value_in = rsp_value_ff;
      rsp_index_in = rsp_index_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      limit_in     = limit_ff;

      if (csr_write && (csr_paddr[2] == ptg_pkg::CSR_REG_LIMIT)) begin
         limit_in = csr_pwdata[ptg_pkg::LIMIT_W-1:0];
      end

      unique case (cw.op)
         ptg_pkg::OP_NOP: begin
         end
         ptg_pkg::OP_ACCEPT: begin
            if (req_valid && req_restart) begin
               count_in = '0;
               last_in  = ptg_pkg::PRIME_THREE;
            end
         end
         ptg_pkg::OP_LOAD_CAND: begin
            n_in = last_ff;
         end
         ptg_pkg::OP_ADVANCE: begin
            n_in = n_ff + ptg_pkg::CAND_STEP;
            k_in = CNT_W'(1);
         end
         ptg_pkg::OP_DIV_START: begin
            d_in       = rd_data_ff;
            rem_in     = '0;
            quo_in     = n_ff;
            div_cnt_in = ptg_pkg::DIV_STEPS;
         end
         ptg_pkg::OP_DIV_STEP: begin
            rem_in     = div_fits ? div_diff[ptg_pkg::VALUE_W-1:0]
                                  : div_shift[ptg_pkg::VALUE_W-1:0];
            quo_in     = {quo_ff[ptg_pkg::VALUE_W-2:0], div_fits};
            div_cnt_in = div_cnt_ff - ptg_pkg::DIV_W'(1);
         end
         ptg_pkg::OP_INC_K: begin
            k_in = k_ff + CNT_W'(1);
         end
         ptg_pkg::OP_SET_TWO: begin
            p_in = ptg_pkg::PRIME_TWO;
         end
         ptg_pkg::OP_SET_THREE: begin
            p_in    = ptg_pkg::PRIME_THREE;
            last_in = ptg_pkg::PRIME_THREE;
         end
         ptg_pkg::OP_SET_CAND: begin
            p_in    = n_ff;
            last_in = n_ff;
         end
         ptg_pkg::OP_STORE: begin
         end
         ptg_pkg::OP_OUT_PRIME: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = p_ff;
               rsp_index_in = ptg_pkg::INDEX_W'(count_ff);
               rsp_done_in  = 1'b0;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         ptg_pkg::OP_OUT_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_index_in = '0;
               rsp_done_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= ptg_pkg::ST_ACCEPT;
         count_ff     <= '0;
         last_ff      <= ptg_pkg::PRIME_THREE;
         limit_ff     <= ptg_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
         k_ff         <= '0;
      end else begin
         pc_ff        <= pc_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff   <= div_cnt_in;
         k_ff         <= k_in;
      end
      n_ff         <= n_in;
      p_ff         <= p_in;
      d_ff         <= d_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_done_ff  <= rsp_done_in;
   end

   // Write new primes, read divisor at k
   always_ff @(posedge clock) begin
      if (cw.op == ptg_pkg::OP_STORE) begin
         prime_mem[count_ff[IDX_W-1:0]] <= p_ff;
      end
      rd_data_ff <= prime_mem[k_ff[IDX_W-1:0]];
   end

   assign req_stall       = pc_ff != ptg_pkg::ST_ACCEPT;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_prime_index = rsp_index_ff;
   assign rsp_done_res    = rsp_done_ff;

   // Accepted request always leaves the wait step
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (pc_ff != ptg_pkg::ST_ACCEPT))
      else $error("sequencer stayed at wait step after accept");

   // Count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PRIMES))
      else $error("produced count beyond table size");

   // Done beats carry no prime
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (rsp_prime_value == '0 && rsp_prime_index == '0))
      else $error("done response carries a prime");

   // Divider never steps with an empty bit count
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == ptg_pkg::ST_DIV_STEP) |-> (div_cnt_ff != '0))
      else $error("divider step with no bits left");

endmodule

// File: test/prime_table_generator_test.sv
`timescale 1ns / 1ps

module prime_table_generator_test;

   localparam int TABLE_DEPTH = 512;
   localparam int SETTLE_CYCLES = 10;
   localparam logic [ptg_pkg::CSR_ADDR_W-1:0] LIMIT_ADDR = {ptg_pkg::CSR_REG_LIMIT, 2'b00};
   localparam bit TYPED = 1'b1;
   localparam bit CALC = 1'b0;
   localparam bit SET_LIMIT = 1'b1;
   localparam bit KEEP_LIMIT = 1'b0;

   typedef struct packed {
      logic [ptg_pkg::VALUE_W-1:0] value;
      logic [ptg_pkg::INDEX_W-1:0] index;
      logic                        done;
   } prime_beat_type;

   typedef struct packed {
      bit                          set_cfg;
      logic [ptg_pkg::LIMIT_W-1:0] cfg_val;
      bit                          restart;
      bit                          typed;
      prime_beat_type              beat;
   } plan_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic                             req_restart;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [ptg_pkg::VALUE_W-1:0]      rsp_prime_value;
   logic [ptg_pkg::INDEX_W-1:0]      rsp_prime_index;
   logic                             rsp_done_res;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [ptg_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [ptg_pkg::CSR_DATA_W-1:0]   csr_pwdata;
   logic [ptg_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                             csr_pready;

   // Predictor state
   logic [ptg_pkg::VALUE_W-1:0] prime_mem [TABLE_DEPTH];
   int unsigned                 primes_made;
   int unsigned                 last_odd;
   logic [ptg_pkg::LIMIT_W-1:0] limit_shadow;

   prime_beat_type pending_primes [$];
   plan_row_type   plan_q [$];
   int unsigned    fail_count;

   prime_table_generator #(
      .MAX_PRIMES(TABLE_DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_value(rsp_prime_value),
      .rsp_prime_index(rsp_prime_index),
      .rsp_done_res   (rsp_done_res),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Compute the beat for one request and advance the prime table
   function automatic prime_beat_type next_prime_beat(input bit restart);
      prime_beat_type beat;
      int unsigned cap;
      int unsigned cand;
      int unsigned k;
      int unsigned d;
      bit          found;
      beat = '0;
      if (restart) begin
         primes_made = 0;
         last_odd = 3;
      end
      cap = (limit_shadow > TABLE_DEPTH) ? TABLE_DEPTH : limit_shadow;
      if (primes_made >= cap) begin
         beat.done = 1'b1;
         return beat;
      end
      if (primes_made == 0) begin
         cand = 2;
      end else if (primes_made == 1) begin
         cand = 3;
         last_odd = 3;
      end else begin
         cand = last_odd;
         found = 1'b0;
         while (!found) begin
            cand += 2;
            found = 1'b1;
            // divide by stored odd primes until a factor or quotient <= divisor
            for (k = 1; k < primes_made && k < TABLE_DEPTH; k++) begin
               d = prime_mem[k];
               if (d == 0) break;
               if (cand % d == 0) begin
                  found = 1'b0;
                  break;
               end
               if (cand / d <= d) break;
            end
         end
         cand = cand & ((1 << ptg_pkg::VALUE_W) - 1);
         last_odd = cand;
      end
      prime_mem[primes_made] = cand[ptg_pkg::VALUE_W-1:0];
      beat.value = cand[ptg_pkg::VALUE_W-1:0];
      beat.index = primes_made[ptg_pkg::INDEX_W-1:0];
      primes_made = primes_made + 1;
      return beat;
   endfunction

   function automatic int unsigned pick_idle(input bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic int unsigned pick_run_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 20);
      if (r < 95) return $urandom_range(21, 60);
      return $urandom_range(61, 150);
   endfunction

   function automatic void add_row(input bit set_cfg, input int unsigned cfg_val,
                                   input bit restart, input bit typed,
                                   input int unsigned value, input int unsigned index,
                                   input bit done);
      plan_row_type row;
      row.set_cfg = set_cfg;
      row.cfg_val = cfg_val[ptg_pkg::LIMIT_W-1:0];
      row.restart = restart;
      row.typed = typed;
      row.beat.value = value[ptg_pkg::VALUE_W-1:0];
      row.beat.index = index[ptg_pkg::INDEX_W-1:0];
      row.beat.done = done;
      plan_q.push_back(row);
   endfunction

   // Send one request beat; queue its expected response on accept
   task automatic send_request(input bit restart, input bit calm, input bit use_given,
                               input prime_beat_type given);
      int unsigned gap;
      prime_beat_type calc;
      gap = pick_idle(calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      calc = next_prime_beat(restart);
      pending_primes.push_back(use_given ? given : calc);
   endtask

   // Drop valid and wait until every response is back
   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_primes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit write, input logic [ptg_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [ptg_pkg::CSR_DATA_W-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_limit_readback(input logic [ptg_pkg::LIMIT_W-1:0] want);
      logic [ptg_pkg::CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, '0, rdata);
      if (rdata[ptg_pkg::LIMIT_W-1:0] !== want) begin
         $error("prime_limit readback expected %0d got %0d", want,
                rdata[ptg_pkg::LIMIT_W-1:0]);
         fail_count++;
      end
   endtask

   // Write prime_limit while idle, then read it back
   task automatic write_limit(input logic [ptg_pkg::LIMIT_W-1:0] val);
      logic [ptg_pkg::CSR_DATA_W-1:0] wdata;
      logic [ptg_pkg::CSR_DATA_W-1:0] rdata;
      quiesce();
      wdata = $urandom;
      wdata[ptg_pkg::LIMIT_W-1:0] = val;
      csr_access(1'b1, wdata, rdata);
      limit_shadow = val;
      check_limit_readback(val);
   endtask

   // Check each response beat against the oldest expectation
   always @(posedge clock) begin
      prime_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_primes.size() == 0) begin
            $error("response beat with no request outstanding: value %0d index %0d done %0d",
                   rsp_prime_value, rsp_prime_index, rsp_done_res);
            fail_count++;
         end else begin
            want = pending_primes.pop_front();
            if (rsp_prime_value !== want.value) begin
               $error("prime_value expected %0d got %0d", want.value, rsp_prime_value);
               fail_count++;
            end
            if (rsp_prime_index !== want.index) begin
               $error("prime_index expected %0d got %0d", want.index, rsp_prime_index);
               fail_count++;
            end
            if (rsp_done_res !== want.done) begin
               $error("done_res expected %0d got %0d", want.done, rsp_done_res);
               fail_count++;
            end
         end
      end
   end

   // Stall responses in bursts, with quiet stretches between
   initial begin
      int unsigned n;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 9) < 3) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(20, 200)) @(posedge clock);
         end else begin
            n = pick_idle(1'b0);
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin
      #100_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int unsigned phase;
      int unsigned budget;
      int unsigned sent;
      int unsigned run_len;
      int unsigned j;
      logic [ptg_pkg::LIMIT_W-1:0] lim;
      bit full;
      bit noisy;
      bit lead;
      bit calm;
      bit rs;

      reset = 1'b1;
      req_valid = 1'b0;
      req_restart = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      fail_count = 0;
      primes_made = 0;
      last_odd = 3;
      limit_shadow = ptg_pkg::LIMIT_RESET;
      for (int i = 0; i < TABLE_DEPTH; i++) prime_mem[i] = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_limit_readback(ptg_pkg::LIMIT_RESET);

      // Directed plan: first request after reset acts as a restart
      add_row(KEEP_LIMIT, 0, 1'b0, TYPED, 2, 0, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, TYPED, 3, 1, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, TYPED, 5, 2, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, TYPED, 7, 3, 1'b0);
      // restart mid-sequence, then back to back
      add_row(KEEP_LIMIT, 0, 1'b1, TYPED, 2, 0, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, TYPED, 3, 1, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b1, TYPED, 2, 0, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b1, TYPED, 2, 0, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, CALC, 0, 0, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, CALC, 0, 0, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, CALC, 0, 0, 1'b0);
      // limit lowered below the count: done until restart
      add_row(SET_LIMIT, 2, 1'b0, TYPED, 0, 0, 1'b1);
      add_row(KEEP_LIMIT, 0, 1'b0, TYPED, 0, 0, 1'b1);
      add_row(KEEP_LIMIT, 0, 1'b1, TYPED, 2, 0, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, TYPED, 3, 1, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, TYPED, 0, 0, 1'b1);
      // zero limit: always done; then a limit of one
      add_row(SET_LIMIT, 0, 1'b1, TYPED, 0, 0, 1'b1);
      add_row(KEEP_LIMIT, 0, 1'b0, TYPED, 0, 0, 1'b1);
      add_row(SET_LIMIT, 1, 1'b1, TYPED, 2, 0, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, TYPED, 0, 0, 1'b1);
      // limit above table size saturates
      add_row(SET_LIMIT, 1023, 1'b1, TYPED, 2, 0, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, TYPED, 3, 1, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, CALC, 0, 0, 1'b0);
      add_row(KEEP_LIMIT, 0, 1'b0, CALC, 0, 0, 1'b0);

      foreach (plan_q[i]) begin
         if (plan_q[i].set_cfg) write_limit(plan_q[i].cfg_val);
         send_request(plan_q[i].restart, 1'($urandom_range(0, 1)), plan_q[i].typed,
                      plan_q[i].beat);
      end

      // Random phases: mostly restart-led runs, some with stray restarts
      for (phase = 0; phase < 11; phase++) begin
         full = 1'b0;
         budget = 100;
         case (phase)
            0: begin
               lim = 10'd1023;
               budget = 520;
               full = 1'b1;
            end
            1: lim = 10'd512;
            2: begin
               lim = 10'd0;
               budget = 30;
            end
            3: begin
               lim = 10'd1;
               budget = 40;
            end
            4: begin
               lim = 10'd2;
               budget = 40;
            end
            5: begin
               lim = 10'd3;
               budget = 30;
            end
            9: lim = 10'd511;
            10: lim = ptg_pkg::LIMIT_RESET;
            default: lim = ptg_pkg::LIMIT_W'($urandom_range(4, 120));
         endcase
         write_limit(lim);
         sent = 0;
         while (sent < budget) begin
            run_len = full ? budget : pick_run_len();
            if (run_len > budget - sent) run_len = budget - sent;
            noisy = !full && ($urandom_range(0, 5) == 0);
            lead = full || ($urandom_range(0, 9) != 0);
            calm = ($urandom_range(0, 3) == 0);
            for (j = 0; j < run_len; j++) begin
               if (j == 0) rs = lead;
               else if (noisy) rs = ($urandom_range(0, 7) == 0);
               else rs = 1'b0;
               send_request(rs, calm, CALC, '0);
            end
            sent += run_len;
         end
      end

      quiesce();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
